/* hw/rtl/swrc_pkg.sv */
// ---------------------------------------------------------------------------
// swrc_pkg
// Shared types and constants of the sliding-window rate counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrc_pkg;

	localparam int WINDOW_SECONDS_DEF = 5;
	localparam int COUNT_BITS_DEF     = 16;

	localparam int TS_W    = 32;
	localparam int TOTAL_W = 19;
	localparam int LOAD_W  = 24;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [LOAD_W-1:0]  LOAD_MAX  = '1;

	typedef enum logic [1:0] {
		CMD_RECORD_RD  = 2'd0,
		CMD_RECORD_WR  = 2'd1,
		CMD_MEASURE_RD = 2'd2,
		CMD_MEASURE_WR = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [TS_W-1:0] timestamp;
	} req_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] window_total;
		logic [LOAD_W-1:0]  load_q8;
		logic               late_stamp;
	} rsp_t;

	// counter select and record flag of a command
	typedef struct packed {
		logic record;
		logic ctr;
	} cmd_dec_t;

	function automatic cmd_dec_t decode_cmd(input cmd_t cmd);
		cmd_dec_t d;
		unique case (cmd)
			CMD_RECORD_RD:  d = '{record: 1'b1, ctr: 1'b0};
			CMD_RECORD_WR:  d = '{record: 1'b1, ctr: 1'b1};
			CMD_MEASURE_RD: d = '{record: 1'b0, ctr: 1'b0};
			CMD_MEASURE_WR: d = '{record: 1'b0, ctr: 1'b1};
			default:        d = '{record: 1'b0, ctr: 1'b0};
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/swrc_stream_if.sv */
// ---------------------------------------------------------------------------
// swrc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swrc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/swrc_load_calc.sv */
// ---------------------------------------------------------------------------
// swrc_load_calc
// Saturates the running total and computes total * 256 / window by a
// reciprocal multiply; one register stage after the multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrc_load_calc
	import swrc_pkg::*;
#(
	parameter int WINDOW_SECONDS = WINDOW_SECONDS_DEF,
	parameter int TW             = 20
) (
	input  logic               clk,
	input  logic               start,
	input  logic [TW-1:0]      total,
	output logic [TOTAL_W-1:0] window_total,
	output logic [LOAD_W-1:0]  load_q8
);

	// exact for any numerator below 2^NUM_W (round-up reciprocal)
	localparam int NUM_W = TOTAL_W + 8;
	localparam int LG    = $clog2(WINDOW_SECONDS);
	localparam int SH    = NUM_W + LG;
	localparam int MW    = NUM_W + 1;
	localparam int PRW   = TOTAL_W + MW;
	localparam int EW    = (TW > TOTAL_W) ? TW : TOTAL_W;
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(WINDOW_SECONDS) - 64'd1)
		/ 64'(WINDOW_SECONDS));

	logic [EW-1:0]      tot_ext;
	logic [TOTAL_W-1:0] sat;
	logic [TOTAL_W-1:0] sat_s1;
	logic [PRW-1:0]     prod_s1;
	logic [PRW-1:0]     quo;

	assign tot_ext = EW'(total);
	assign sat     = (tot_ext > EW'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			sat_s1  <= sat;
			prod_s1 <= PRW'(sat) * PRW'(RECIP);
		end
	end

	// x*256/W == x*RECIP >> (SH-8)
	assign quo          = prod_s1 >> (SH - 8);
	assign window_total = sat_s1;
	assign load_q8      = (|quo[PRW-1:LOAD_W]) ? LOAD_MAX : quo[LOAD_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/sliding_window_rate_counter.sv */
// ---------------------------------------------------------------------------
// sliding_window_rate_counter
// Two per-second bucket rings (reads, writes) with rolling totals and load.
// ---------------------------------------------------------------------------
// One transaction at a time. A command on an empty counter passes from
// acceptance through the NEWEST, LOAD and DONE states to its result. A
// command that finds live buckets first passes through EVICT once for each
// ring bucket it examines: every bucket it evicts, and the oldest bucket that
// stays, if one is left (up to WINDOW_SECONDS in all). The bucket memory
// gives one read per cycle and eviction walks the ring from its oldest
// bucket. The result sits in an output register, so the next command is
// taken while it waits; a command only stalls at its end if the previous
// result has still not been taken. Bucket storage needs no clearing after
// reset: only values read from live buckets are ever used.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_rate_counter
	import swrc_pkg::*;
#(
	parameter int WINDOW_SECONDS = WINDOW_SECONDS_DEF,
	parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	swrc_stream_if.sink   req,
	swrc_stream_if.source rsp
);

	localparam int SLOTS = 2 * WINDOW_SECONDS;
	localparam int PW    = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
	localparam int FW    = $clog2(WINDOW_SECONDS + 1);
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TW    = COUNT_BITS + FW;
	localparam int SW    = ((PW > FW) ? PW : FW) + 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EVICT  = 5'b00010,
		ST_NEWEST = 5'b00100,
		ST_LOAD   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// bucket memories, one entry per slot
	logic [TS_W-1:0]       time_mem [SLOTS];
	logic [COUNT_BITS-1:0] count_mem [SLOTS];
	logic [TS_W-1:0]       time_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;

	logic [PW-1:0] oldest_q [2];
	logic [FW-1:0] fill_q [2];
	logic [TW-1:0] total_q [2];

	logic            rec_q;
	logic            ctr_q;
	logic [TS_W-1:0] ts_q;
	logic            late_q;
	logic            valid_q;
	rsp_t            rsp_q;

	cmd_dec_t in_dec;
	logic     accept;
	logic     cur_c;
	logic [PW-1:0] cur_old, nxt_old, tail_pos, newest_pos;
	logic [FW-1:0] cur_fill;
	logic [TW-1:0] cur_tot;
	logic [SW-1:0] tail_sum, newest_sum;

	logic            evict_hit, have, late_now, bump;
	logic            evict_go, bump_go, open_go, calc_start, rsp_load;
	logic            rd_en, cnt_we, time_we;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [COUNT_BITS-1:0] cnt_wd;

	logic [TOTAL_W-1:0] calc_total;
	logic [LOAD_W-1:0]  calc_load;

	function automatic logic [AW-1:0] slot_addr(input logic c, input logic [PW-1:0] pos);
		return c ? AW'(WINDOW_SECONDS) + AW'(pos) : AW'(pos);
	endfunction

	assign in_dec = decode_cmd(req.payload.cmd);
	assign accept = req.valid && req.ready;
	assign cur_c  = (state_q == ST_IDLE) ? in_dec.ctr : ctr_q;

	assign cur_old  = oldest_q[cur_c];
	assign cur_fill = fill_q[cur_c];
	assign cur_tot  = total_q[cur_c];

	assign nxt_old    = (cur_old == PW'(WINDOW_SECONDS - 1)) ? '0 : cur_old + PW'(1);
	assign tail_sum   = SW'(cur_old) + SW'(cur_fill);
	assign newest_sum = tail_sum - SW'(1);
	assign tail_pos   = (tail_sum >= SW'(WINDOW_SECONDS)) ?
		PW'(tail_sum - SW'(WINDOW_SECONDS)) : PW'(tail_sum);
	assign newest_pos = (newest_sum >= SW'(WINDOW_SECONDS)) ?
		PW'(newest_sum - SW'(WINDOW_SECONDS)) : PW'(newest_sum);

	// time + W <= now, no wrap
	assign evict_hit = ({1'b0, time_rd_q} + 33'(WINDOW_SECONDS)) <= {1'b0, ts_q};
	assign have      = (cur_fill != '0);
	assign late_now  = have && (time_rd_q > ts_q);
	assign bump      = have && ((time_rd_q >= ts_q) || (cur_fill >= FW'(WINDOW_SECONDS)));

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = '0;
		evict_go   = 1'b0;
		bump_go    = 1'b0;
		open_go    = 1'b0;
		calc_start = 1'b0;
		rsp_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_en   = 1'b1;
					rd_addr = slot_addr(in_dec.ctr, cur_old);
					state_d = have ? ST_EVICT : ST_NEWEST;
				end
			end
			ST_EVICT: begin
				rd_en = 1'b1;
				if (evict_hit) begin
					evict_go = 1'b1;
					rd_addr  = slot_addr(ctr_q, nxt_old);
					if (cur_fill == FW'(1))
						state_d = ST_NEWEST;
				end else begin
					rd_addr = slot_addr(ctr_q, newest_pos);
					state_d = ST_NEWEST;
				end
			end
			ST_NEWEST: begin
				if (rec_q) begin
					if (bump)
						bump_go = (cnt_rd_q != '1);
					else
						open_go = 1'b1;
				end
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				calc_start = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cnt_we  = bump_go || open_go;
	assign time_we = open_go;
	assign wr_addr = bump_go ? slot_addr(ctr_q, newest_pos) : slot_addr(ctr_q, tail_pos);
	assign cnt_wd  = bump_go ? cnt_rd_q + COUNT_BITS'(1) : COUNT_BITS'(1);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			time_rd_q <= time_mem[rd_addr];
			cnt_rd_q  <= count_mem[rd_addr];
		end
		if (time_we)
			time_mem[wr_addr] <= ts_q;
		if (cnt_we)
			count_mem[wr_addr] <= cnt_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '{default: '0};
			fill_q   <= '{default: '0};
			total_q  <= '{default: '0};
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (evict_go) begin
				total_q[ctr_q]  <= cur_tot - TW'(cnt_rd_q);
				oldest_q[ctr_q] <= nxt_old;
				fill_q[ctr_q]   <= cur_fill - FW'(1);
			end
			if (bump_go)
				total_q[ctr_q] <= cur_tot + TW'(1);
			if (open_go) begin
				total_q[ctr_q] <= cur_tot + TW'(1);
				fill_q[ctr_q]  <= cur_fill + FW'(1);
			end
			if (rsp_load)
				valid_q <= 1'b1;
			else if (rsp.ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q <= in_dec.record;
			ctr_q <= in_dec.ctr;
			ts_q  <= req.payload.timestamp;
		end
		if (state_q == ST_NEWEST)
			late_q <= late_now;
		if (rsp_load) begin
			rsp_q.window_total <= calc_total;
			rsp_q.load_q8      <= calc_load;
			rsp_q.late_stamp   <= late_q;
		end
	end

	swrc_load_calc #(
		.WINDOW_SECONDS(WINDOW_SECONDS),
		.TW(TW)
	) u_load_calc (
		.clk(clk),
		.start(calc_start),
		.total(total_q[ctr_q]),
		.window_total(calc_total),
		.load_q8(calc_load)
	);

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = valid_q;
	assign rsp.payload = rsp_q;

endmodule

`default_nettype wire

/* hw/rtl/swrc_checker.sv */
// ---------------------------------------------------------------------------
// swrc_checker
// Port-level checks of the rate counter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrc_checker
	import swrc_pkg::*;
#(
	parameter int WINDOW_SECONDS = WINDOW_SECONDS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [TOTAL_W-1:0] window_total,
	input logic [LOAD_W-1:0]  load_q8,
	input logic               late_stamp
);

	logic [2:0] pend_q;
	logic       in_go, out_go;

	assign in_go  = req_valid && req_ready;
	assign out_go = rsp_valid && rsp_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_go && !out_go) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_go && !in_go) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_go |=> !req_ready)
		else $error("ready right after an accepted command");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more than two commands in flight");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 3'd0)
		else $error("result without an outstanding command");

	a_load_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && load_q8 != LOAD_MAX |->
			(40'(load_q8) * 40'(WINDOW_SECONDS) <= 40'(window_total) * 40'd256) &&
			(40'(window_total) * 40'd256 < (40'(load_q8) + 40'd1) * 40'(WINDOW_SECONDS)))
		else $error("load does not match total");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(window_total) &&
			$stable(load_q8) && $stable(late_stamp))
		else $error("stalled result changed");

endmodule

bind sliding_window_rate_counter swrc_checker #(
	.WINDOW_SECONDS(WINDOW_SECONDS)
) u_swrc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.window_total(rsp.payload.window_total),
	.load_q8(rsp.payload.load_q8),
	.late_stamp(rsp.payload.late_stamp)
);

`default_nettype wire

/* bench/sliding_window_rate_counter_tb.sv */
// ---------------------------------------------------------------------------
// sliding_window_rate_counter_tb
// Self-checking bench for the read/write sliding-window rate counter.
// ---------------------------------------------------------------------------
// Commands go in through the request channel. Each accepted transaction runs
// through a bucket-ring predictor kept inside the bench. Every response is
// checked field by field against the oldest predicted one. The directed tests
// cover empty counters, eviction, late stamps, a full ring, a burst of events
// within one second and extreme timestamps. Random traffic then follows in
// four idle/stall phases.
`timescale 1ns / 1ps

module sliding_window_rate_counter_tb;
	import swrc_pkg::*;

	localparam int                    WIN       = WINDOW_SECONDS_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] COUNT_SAT = '1;

	logic clk;
	logic arst_n;

	swrc_stream_if #(.T(req_t)) req_if ();
	swrc_stream_if #(.T(rsp_t)) rsp_if ();

	sliding_window_rate_counter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// bench copy of the two bucket rings
	logic [TS_W-1:0]           ring_time  [2][WIN];
	logic [COUNT_BITS_DEF-1:0] ring_count [2][WIN];
	int unsigned               head_pos   [2];
	int unsigned               live_cnt   [2];
	logic [TOTAL_W-1:0]        ring_sum   [2];

	rsp_t pending_rsp [$];

	int send_idle_pct;
	int recv_stall_pct;
	int err_cnt;
	int sent_cnt;
	int record_cnt;
	int checked_cnt;
	int late_cnt;
	int peak_total;
	logic [TS_W-1:0] now_sec;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("sliding_window_rate_counter verification failed");
		$finish;
	end

	// response side: random backpressure
	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic rsp_t predict_rate(input cmd_t cmd, input logic [TS_W-1:0] ts);
		int unsigned c;
		int unsigned newest;
		int unsigned slot;
		logic        record;
		logic [31:0] load_full;
		rsp_t        r;
		c      = (cmd == CMD_RECORD_WR || cmd == CMD_MEASURE_WR) ? 1 : 0;
		record = (cmd == CMD_RECORD_RD || cmd == CMD_RECORD_WR);
		r      = '0;
		// age out old buckets; compare in 33 bits so near-max stamps never wrap
		while (live_cnt[c] > 0 &&
				({1'b0, ring_time[c][head_pos[c]]} + 33'(WIN)) <= {1'b0, ts}) begin
			ring_sum[c] -= TOTAL_W'(ring_count[c][head_pos[c]]);
			ring_count[c][head_pos[c]] = '0;
			head_pos[c] = (head_pos[c] + 1) % WIN;
			live_cnt[c]--;
		end
		if (live_cnt[c] > 0) begin
			newest = (head_pos[c] + live_cnt[c] - 1) % WIN;
			r.late_stamp = (ring_time[c][newest] > ts);
		end
		if (record) begin
			if (live_cnt[c] > 0 && (ring_time[c][newest] >= ts || live_cnt[c] >= WIN)) begin
				// same second, late stamp or full ring: fold into newest bucket, saturating
				if (ring_count[c][newest] != COUNT_SAT) begin
					ring_count[c][newest]++;
					ring_sum[c]++;
				end
			end else begin
				slot = (head_pos[c] + live_cnt[c]) % WIN;
				ring_time[c][slot]  = ts;
				ring_count[c][slot] = COUNT_BITS_DEF'(1);
				live_cnt[c]++;
				ring_sum[c]++;
			end
		end
		r.window_total = ring_sum[c];
		load_full      = ({13'd0, ring_sum[c]} << 8) / WIN;
		r.load_q8      = (load_full > 32'(LOAD_MAX)) ? LOAD_MAX : load_full[LOAD_W-1:0];
		return r;
	endfunction

	task automatic send_cmd(input cmd_t cmd, input logic [TS_W-1:0] ts);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= '{cmd: cmd, timestamp: ts};
		do @(posedge clk); while (!req_if.ready);
		pending_rsp.push_back(predict_rate(cmd, ts));
		sent_cnt++;
		if (cmd == CMD_RECORD_RD || cmd == CMD_RECORD_WR)
			record_cnt++;
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response: total=%0d load=%0d late=%0d",
					rsp_if.payload.window_total, rsp_if.payload.load_q8,
					rsp_if.payload.late_stamp);
				err_cnt++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				checked_cnt++;
				if (rsp_if.payload.late_stamp)
					late_cnt++;
				if (int'(rsp_if.payload.window_total) > peak_total)
					peak_total = int'(rsp_if.payload.window_total);
				if (rsp_if.payload.window_total !== exp_rsp.window_total) begin
					$error("window_total: expected %0d, got %0d",
						exp_rsp.window_total, rsp_if.payload.window_total);
					err_cnt++;
				end
				if (rsp_if.payload.load_q8 !== exp_rsp.load_q8) begin
					$error("load_q8: expected %0d, got %0d",
						exp_rsp.load_q8, rsp_if.payload.load_q8);
					err_cnt++;
				end
				if (rsp_if.payload.late_stamp !== exp_rsp.late_stamp) begin
					$error("late_stamp: expected %0d, got %0d",
						exp_rsp.late_stamp, rsp_if.payload.late_stamp);
					err_cnt++;
				end
			end
		end
	end

	task automatic test_basic_counting();
		send_cmd(CMD_MEASURE_RD, 32'd0);
		send_cmd(CMD_MEASURE_WR, 32'd0);
		send_cmd(CMD_RECORD_RD, 32'd0);
		send_cmd(CMD_RECORD_RD, 32'd0);
		send_cmd(CMD_RECORD_RD, 32'd1);
		send_cmd(CMD_RECORD_WR, 32'd2);
		send_cmd(CMD_MEASURE_RD, 32'd4);
		// second 0 ages out exactly at 5
		send_cmd(CMD_MEASURE_RD, 32'd5);
		drain_results();
	endtask

	task automatic test_late_and_full_ring();
		send_cmd(CMD_RECORD_RD, 32'd9);
		send_cmd(CMD_RECORD_RD, 32'd7);
		send_cmd(CMD_MEASURE_RD, 32'd8);
		for (int t = 10; t <= 13; t++)
			send_cmd(CMD_RECORD_RD, TS_W'(t));
		send_cmd(CMD_RECORD_RD, 32'd14);
		// evicts every live bucket in one command
		send_cmd(CMD_MEASURE_RD, 32'd100);
		drain_results();
	endtask

	task automatic test_same_second_burst();
		for (int i = 0; i < 60; i++)
			send_cmd(CMD_RECORD_WR, 32'd200);
		send_cmd(CMD_MEASURE_WR, 32'd204);
		send_cmd(CMD_MEASURE_WR, 32'd205);
		drain_results();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		int          sel;
		logic [TS_W-1:0] ts;
		cmd_t        cmd;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 55)
				ts = now_sec;
			else if (sel < 80)
				now_sec = now_sec + 1;
			else if (sel < 90)
				now_sec = now_sec + $urandom_range(2, 5);
			else if (sel < 95)
				now_sec = now_sec + $urandom_range(6, 12);
			else if (sel < 97)
				now_sec = now_sec + $urandom_range(13, 1 << 20);
			ts = now_sec;
			// occasional out-of-order stamp
			if (sel >= 97)
				ts = now_sec - $urandom_range(1, 6);
			if ($urandom_range(9) < 7)
				cmd = $urandom_range(1) ? CMD_RECORD_WR : CMD_RECORD_RD;
			else
				cmd = $urandom_range(1) ? CMD_MEASURE_WR : CMD_MEASURE_RD;
			send_cmd(cmd, ts);
		end
		drain_results();
	endtask

	task automatic test_timestamp_extremes();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_cmd(CMD_RECORD_WR, 32'hAAAA_AAAA);
		send_cmd(CMD_RECORD_WR, 32'h5555_5555);
		send_cmd(CMD_RECORD_WR, 32'hFFFF_FFFF);
		send_cmd(CMD_MEASURE_WR, 32'hFFFF_FFFF);
		// no eviction from a wrapped subtraction
		send_cmd(CMD_MEASURE_WR, 32'h0000_0000);
		send_cmd(CMD_RECORD_RD, 32'hFFFF_FFFE);
		send_cmd(CMD_MEASURE_RD, 32'hFFFF_FFFF);
		drain_results();
	endtask

	initial begin
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		err_cnt        = 0;
		sent_cnt       = 0;
		record_cnt     = 0;
		checked_cnt    = 0;
		late_cnt       = 0;
		peak_total     = 0;
		for (int c = 0; c < 2; c++) begin
			head_pos[c] = 0;
			live_cnt[c] = 0;
			ring_sum[c] = '0;
			for (int s = 0; s < WIN; s++) begin
				ring_time[c][s]  = '0;
				ring_count[c][s] = '0;
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_counting();
		test_late_and_full_ring();
		test_same_second_burst();
		now_sec = 32'd300;
		test_random_traffic(0, 0, 240);
		test_random_traffic(46, 0, 240);
		test_random_traffic(0, 46, 240);
		test_random_traffic(26, 26, 240);
		test_timestamp_extremes();

		repeat (16) @(posedge clk);
		$display("%0d commands sent (%0d records), %0d responses checked",
			sent_cnt, record_cnt, checked_cnt);
		$display("%0d late stamps flagged, peak window total %0d", late_cnt, peak_total);
		if (err_cnt == 0)
			$display("sliding_window_rate_counter verification clean");
		else
			$display("sliding_window_rate_counter verification failed");
		$finish;
	end

endmodule
